### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

### design/lcwp_pkg.sv
// ----------------------------------------------------------------------------
// lcwp_pkg
// Shared codes, constants and saturation helper for the weight processor.
// ----------------------------------------------------------------------------
package lcwp_pkg;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_ZERO   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] REG_POINTS       = 3'd0;
  localparam logic [2:0] REG_FILTER_SHIFT = 3'd1;
  localparam logic [2:0] REG_BAND_LIMIT   = 3'd2;
  localparam logic [2:0] REG_ROUND_STEP   = 3'd3;
  localparam logic [2:0] REG_ZERO_BAND    = 3'd4;
  localparam logic [2:0] REG_ZERO_DELAY   = 3'd5;
  localparam logic [2:0] REG_STEADY_BAND  = 3'd6;
  localparam logic [2:0] REG_STEADY_DELAY = 3'd7;

  localparam logic signed [23:0] FAIL_MARK  = -24'sd999999;
  localparam logic [10:0]        STEADY_MAX = 11'd2000;
  localparam logic [11:0]        DELAY_UNIT = 12'd10;

  typedef logic signed [31:0] word_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = word_t'(v);
    return r;
  endfunction

endpackage

### design/load_cell_weight_processor_unit.sv
// Sequence, accept to result valid: set-zero, calibration write, failed-read and unknown
// words go straight to the result; samples search the calibration segments, then use a
// 25-step serial multiply and a 57-step restoring division, and a second 57-step division
// with rounding on, all on one shared datapath. A held result stalls it.
// Flow: one word at a time; the next word can be taken once the result is presented.
// Reset: control, registers and state clear; the calibration memory does not.
// ----------------------------------------------------------------------------
// load_cell_weight_processor_unit
// Filter, piecewise-linear calibration, offset, rounding, zero tracking and
// stability detection for load-cell converter samples.
// ----------------------------------------------------------------------------
module load_cell_weight_processor_unit #(
  parameter int MAX_POINTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [22:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // adc_sample[23:0], point_index[26:24], point_adc[50:27], point_weight[82:51]
  input  logic [87:0] s_tdata,
  // operation[1:0], read_failed[2]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // raw_echo[23:0], weight[55:24], zero_offset[87:56]
  output logic [87:0] m_tdata,
  // stable[0], zero_refused[1]
  output logic [1:0]  m_tuser
);
  import lcwp_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_LRD  = 4'd4;
  localparam logic [3:0] S_LGET = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_DIV1 = 4'd7;
  localparam logic [3:0] S_CAL  = 4'd8;
  localparam logic [3:0] S_ADD  = 4'd9;
  localparam logic [3:0] S_DIV2 = 4'd10;
  localparam logic [3:0] S_RND  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0] state;

  // configuration
  logic [3:0]  points_in_use;
  logic [4:0]  filter_shift;
  logic [22:0] filter_band;
  logic [15:0] round_step, zero_band, steady_band;
  logic [7:0]  zero_delay, steady_delay;

  // captured word
  logic [1:0]         op;
  logic               failed;
  logic signed [23:0] sample, padc;
  logic [2:0]         pidx;
  word_t              pw;

  // processing state
  logic signed [23:0] filter_value;
  logic               seeded;
  word_t              offset, last_weight, steady_reference;
  logic [11:0]        zero_count;
  logic [10:0]        steady_count;
  logic               steady_flag;

  // calibration memory: {weight, adc}
  logic [55:0] cal_mem [MAX_POINTS];
  logic [55:0] rd_data;
  logic [AW-1:0] raddr, j;
  logic signed [23:0] rd_adc;
  word_t              rd_w;

  // datapath
  logic signed [23:0] x, x1;
  word_t              y0, y1, cal, w;
  logic [24:0]  mplier, dvs, rem;
  logic [32:0]  mcand, rmag;
  logic [56:0]  num;
  logic [5:0]   cnt;
  logic         neg, wneg;

  logic [NW-1:0] n;
  always_comb begin
    if (32'(points_in_use) > MAX_POINTS) n = NW'(MAX_POINTS);
    else n = NW'(points_in_use);
  end

  assign rd_adc = rd_data[23:0];
  assign rd_w   = rd_data[55:24];
  assign raddr  = (state == S_LRD) ? j - AW'(1) : j;

  // filter
  logic signed [24:0] fd;
  logic signed [23:0] fv_new;
  logic [23:0]        fbase;
  always_comb begin
    fbase = seeded ? filter_value : sample;
    fd = 25'(sample) - 25'($signed(fbase));
    if (filter_shift == 5'd0) fv_new = sample;
    else if (fd > $signed({2'b00, filter_band}) || fd < -$signed({2'b00, filter_band}))
      fv_new = sample;
    else fv_new = 24'($signed(fbase) + (fd >>> filter_shift));
  end

  // segment endpoint differences
  logic signed [24:0] dx, den;
  logic signed [32:0] dy;
  always_comb begin
    dx  = 25'(x) - 25'(rd_adc);
    den = 25'(x1) - 25'(rd_adc);
    dy  = 33'(y1) - 33'(rd_w);
  end

  // shared divide step
  logic [25:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem, num[56]};
  assign ge     = rem_sh >= {1'b0, dvs};

  // calibrated weight and rounding front end
  logic signed [58:0] qs;
  word_t              w0;
  logic [32:0]        m;
  logic [32:0]        rmag_r;
  logic signed [33:0] ws;
  always_comb begin
    qs = neg ? -$signed({2'b00, num}) : $signed({2'b00, num});
    w0 = sat32(64'(cal) + 64'(offset));
    if (w0[31]) m = 33'(-64'(w0)) + 33'(round_step >> 1);
    else m = 33'(w0) + 33'(round_step >> 1);
    rmag_r = rmag - 33'(rem);
    ws = wneg ? -$signed({1'b0, rmag_r}) : $signed({1'b0, rmag_r});
  end

  // commit values
  word_t       off_n, lw_n, ref_n;
  logic [11:0] zc_n, zc_inc;
  logic [10:0] sc_n, sc_inc;
  logic        flag_n, refused;
  logic signed [32:0] sd;
  logic        fin_go;
  logic signed [23:0] raw;

  assign fin_go = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    off_n = offset; lw_n = last_weight; ref_n = steady_reference;
    zc_n = zero_count; sc_n = steady_count; flag_n = steady_flag;
    refused = 1'b0; raw = 24'sd0;
    zc_inc = zero_count + 12'd1;
    sc_inc = (steady_count < STEADY_MAX) ? steady_count + 11'd1 : steady_count;
    sd = 33'(w) - 33'(steady_reference);
    if (op == OP_SAMPLE) begin
      raw = failed ? FAIL_MARK : sample;
      if (!failed) begin
        lw_n = w;
        if (zero_band != 16'd0) begin
          if (33'(w) > -$signed({17'd0, zero_band}) && 33'(w) < $signed({17'd0, zero_band}))
          begin
            zc_n = zc_inc;
            if (zc_inc > {4'd0, zero_delay} * DELAY_UNIT) begin
              off_n = sat32(64'(offset) - 64'(w));
              zc_n = 12'd0;
            end
          end else begin
            zc_n = 12'd0;
          end
        end
        if (sd >= -$signed({17'd0, steady_band}) && sd <= $signed({17'd0, steady_band}))
        begin
          sc_n = sc_inc;
          if ({1'b0, sc_inc} >= {4'd0, steady_delay} * DELAY_UNIT) flag_n = 1'b1;
        end else begin
          ref_n = w; sc_n = 11'd0; flag_n = 1'b0;
        end
      end
    end else if (op == OP_ZERO) begin
      if (!steady_flag) refused = 1'b1;
      else begin
        off_n = sat32(64'(offset) - 64'(last_weight));
        zc_n = 12'd0;
      end
    end
  end

  assign s_tready = (state == S_IDLE);

  // memory
  always_ff @(posedge clk) begin
    if (state == S_DISP && op == OP_WRITE && 32'(pidx) < MAX_POINTS)
      cal_mem[AW'(pidx)] <= {pw, padc};
    rd_data <= cal_mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0; filter_shift <= '0; filter_band <= '0; round_step <= '0;
      zero_band <= '0; zero_delay <= '0; steady_band <= '0; steady_delay <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POINTS:       points_in_use <= cfg_wdata[3:0];
        REG_FILTER_SHIFT: filter_shift  <= cfg_wdata[4:0];
        REG_BAND_LIMIT:   filter_band   <= cfg_wdata;
        REG_ROUND_STEP:   round_step    <= cfg_wdata[15:0];
        REG_ZERO_BAND:    zero_band     <= cfg_wdata[15:0];
        REG_ZERO_DELAY:   zero_delay    <= cfg_wdata[7:0];
        REG_STEADY_BAND:  steady_band   <= cfg_wdata[15:0];
        REG_STEADY_DELAY: steady_delay  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op <= s_tuser[1:0]; failed <= s_tuser[2];
      sample <= s_tdata[23:0]; pidx <= s_tdata[26:24];
      padc <= s_tdata[50:27]; pw <= s_tdata[82:51];
    end
    case (state)
      S_DISP: begin
        x <= fv_new; j <= AW'(1); cal <= '0;
      end
      S_SCMP: begin
        x1 <= rd_adc; y1 <= rd_w;
        if (!(x < rd_adc || NW'(j) + NW'(1) == n)) j <= j + AW'(1);
      end
      S_LGET: begin
        y0 <= rd_w; cal <= rd_w;
        mplier <= dx[24] ? 25'(-dx) : 25'(dx);
        mcand  <= dy[32] ? 33'(-dy) : 33'(dy);
        dvs    <= den[24] ? 25'(-den) : 25'(den);
        neg    <= dx[24] ^ dy[32] ^ den[24];
        num <= '0; cnt <= 6'd24;
      end
      S_MUL: begin
        num <= (num << 1) + (mplier[24] ? 57'(mcand) : 57'd0);
        mplier <= mplier << 1;
        if (cnt == 6'd0) begin
          cnt <= 6'd56; rem <= '0;
        end else cnt <= cnt - 6'd1;
      end
      S_DIV1, S_DIV2: begin
        rem <= ge ? 25'(rem_sh - {1'b0, dvs}) : rem_sh[24:0];
        num <= {num[55:0], ge};
        cnt <= cnt - 6'd1;
      end
      S_CAL: cal <= sat32(64'(y0) + 64'(qs));
      S_ADD: begin
        w <= w0; rmag <= m; wneg <= w0[31];
        num <= 57'(m); dvs <= 25'(round_step); rem <= '0; cnt <= 6'd56;
      end
      S_RND: w <= sat32(64'(ws));
      default: ;
    endcase
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      filter_value <= '0; seeded <= 1'b0; offset <= '0; last_weight <= '0;
      zero_count <= '0; steady_count <= '0; steady_reference <= '0;
      steady_flag <= 1'b0; m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !fin_go) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid) state <= S_DISP;
        S_DISP: begin
          if (op == OP_SAMPLE && !failed) begin
            filter_value <= fv_new; seeded <= 1'b1;
            state <= (n < NW'(2)) ? S_ADD : S_SRD;
          end else state <= S_FIN;
        end
        S_SRD:  state <= S_SCMP;
        S_SCMP: state <= (x < rd_adc || NW'(j) + NW'(1) == n) ? S_LRD : S_SRD;
        S_LRD:  state <= S_LGET;
        S_LGET: state <= (den == 25'sd0) ? S_ADD : S_MUL;
        S_MUL:  if (cnt == 6'd0) state <= S_DIV1;
        S_DIV1: if (cnt == 6'd0) state <= S_CAL;
        S_CAL:  state <= S_ADD;
        S_ADD:  state <= (round_step > 16'd1) ? S_DIV2 : S_FIN;
        S_DIV2: if (cnt == 6'd0) state <= S_RND;
        S_RND:  state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            offset <= off_n; last_weight <= lw_n; steady_reference <= ref_n;
            zero_count <= zc_n; steady_count <= sc_n; steady_flag <= flag_n;
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (fin_go) begin
      m_tdata <= {off_n, lw_n, raw};
      m_tuser <= {refused, flag_n};
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_NEXT(a_fin_delivers, clk, rst, fin_go, m_tvalid && state == S_IDLE)
  `ASSERT_IMPLIES(a_refused_unstable, clk, rst, m_tvalid && m_tuser[1], !m_tuser[0])

endmodule

### tb/sv/load_cell_weight_processor_unit_tb.sv
// ----------------------------------------------------------------------------
// load_cell_weight_processor_unit_tb
// Drives samples, set-zero commands and calibration writes through the stream
// ports, predicts every result word with a local weighing model and compares
// each field. Several register settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module load_cell_weight_processor_unit_tb;
  import lcwp_pkg::*;

  localparam int NPTS = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [22:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [1:0]  m_tuser;

  typedef struct packed {
    logic signed [23:0] raw;
    logic signed [31:0] wgt;
    logic               stb;
    logic signed [31:0] offs;
    logic               refused;
  } reading_t;

  typedef struct {
    logic [1:0]         op;
    logic               fail;
    logic signed [23:0] sample;
    logic [2:0]         idx;
    logic signed [23:0] padc;
    logic signed [31:0] pwgt;
    bit                 has_exp;
    reading_t           exp_r;
  } row_t;

  load_cell_weight_processor_unit #(.MAX_POINTS(NPTS)) uut (.*);

  always #5 clk = ~clk;

  // predictor state
  int unsigned n_pts, f_shift, f_band, r_step, z_band, z_delay, s_band, s_delay;
  logic signed [31:0] filt, offs_m, last_w, s_ref;
  bit seeded, s_flag;
  int unsigned z_cnt, s_cnt;
  logic signed [31:0] tab_adc [NPTS];
  logic signed [31:0] tab_wgt [NPTS];

  reading_t pending_q[$];
  int errors = 0;
  int send_idle = 12, recv_idle = 72;
  bit hold_off = 1'b0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint floor_shr(longint v, int unsigned s);
    if (v >= 0) return v >>> s;
    return -((-v - 1) >>> s) - 1;
  endfunction

  function automatic logic signed [31:0] interpolate(logic signed [31:0] x);
    int unsigned n, i;
    longint x0, x1, y0, y1;
    n = (n_pts > NPTS) ? NPTS : n_pts;
    if (n < 2) return 0;
    for (i = 0; i + 1 < n; i++)
      if (x < tab_adc[i+1]) break;
    if (i >= n - 1) i = n - 2;
    x0 = tab_adc[i]; x1 = tab_adc[i+1]; y0 = tab_wgt[i]; y1 = tab_wgt[i+1];
    if (x1 == x0) return y0[31:0];
    return clamp32(y0 + (longint'(x) - x0) * (y1 - y0) / (x1 - x0));
  endfunction

  function automatic reading_t weigh(row_t r);
    reading_t o;
    longint w, d, st;
    o = '0;
    if (r.op == OP_SAMPLE) begin
      if (r.fail) o.raw = FAIL_MARK;
      else begin
        o.raw = r.sample;
        if (!seeded) begin filt = r.sample; seeded = 1; end
        if (f_shift == 0) filt = r.sample;
        else begin
          d = longint'(r.sample) - filt;
          if (d > longint'(f_band) || d < -longint'(f_band)) filt = r.sample;
          else filt = 32'(filt + floor_shr(d, f_shift));
        end
        w = clamp32(longint'(interpolate(filt)) + offs_m);
        if (r_step > 1) begin
          st = r_step;
          if (w >= 0) w = (w + st / 2) / st * st;
          else w = (w - st / 2) / st * st;
          w = clamp32(w);
        end
        last_w = 32'(w);
        if (z_band > 0) begin
          if (w > -longint'(z_band) && w < longint'(z_band)) begin
            z_cnt++;
            if (z_cnt > z_delay * 10) begin
              offs_m = clamp32(longint'(offs_m) - w);
              z_cnt = 0;
            end
          end else z_cnt = 0;
        end
        d = w - s_ref;
        if (d >= -longint'(s_band) && d <= longint'(s_band)) begin
          if (s_cnt < 2000) s_cnt++;
          if (s_cnt >= s_delay * 10) s_flag = 1;
        end else begin
          s_ref = 32'(w); s_cnt = 0; s_flag = 0;
        end
      end
    end else if (r.op == OP_ZERO) begin
      if (!s_flag) o.refused = 1;
      else begin
        offs_m = clamp32(longint'(offs_m) - last_w);
        z_cnt = 0;
      end
    end else if (r.op == OP_WRITE) begin
      tab_adc[r.idx] = r.padc; tab_wgt[r.idx] = r.pwgt;
    end
    o.wgt = last_w; o.stb = s_flag; o.offs = offs_m;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] a, int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= v[22:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_POINTS:       n_pts = v & 4'hf;
      REG_FILTER_SHIFT: f_shift = v & 5'h1f;
      REG_BAND_LIMIT:   f_band = v & 23'h7fffff;
      REG_ROUND_STEP:   r_step = v & 16'hffff;
      REG_ZERO_BAND:    z_band = v & 16'hffff;
      REG_ZERO_DELAY:   z_delay = v & 8'hff;
      REG_STEADY_BAND:  s_band = v & 16'hffff;
      default:          s_delay = v & 8'hff;
    endcase
  endtask

  // valid stays up from one word to the next; idle cycles drop it
  task automatic send(row_t r);
    reading_t e;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {r.fail, r.op};
    s_tdata <= {5'b0, r.pwgt, r.padc, r.idx, r.sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e = weigh(r);
    if (r.has_exp && e !== r.exp_r) begin
      $display("%0t directed row mispredicted: table %h model %h", $time, r.exp_r, e);
      errors++;
    end
    pending_q.push_back(e);
  endtask

  task automatic drain();
    int n = 0;
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0 && n < 200000) begin @(posedge clk); n++; end
    repeat (200) @(posedge clk);
  endtask

  function automatic row_t mk(logic [1:0] op, logic f, int s, int i, int a, int w);
    row_t r;
    r.op = op; r.fail = f; r.sample = 24'(s); r.idx = 3'(i); r.padc = 24'(a); r.pwgt = w;
    r.has_exp = 0; r.exp_r = '0;
    return r;
  endfunction

  task automatic random_items(int count);
    row_t r;
    int k;
    logic signed [23:0] base;
    base = 24'($urandom);
    for (k = 0; k < count; k++) begin
      r = mk(OP_SAMPLE, 0, 0, $urandom, $urandom, $urandom);
      case ($urandom_range(19))
        0: r.op = OP_ZERO;
        1: r.op = OP_NONE;
        2: r.fail = 1;
        3: r.sample = 24'($urandom);
        4, 5: begin base = 24'($urandom); r.sample = base; end
        default: r.sample = 24'(base + $signed($urandom_range(64)) - 32);
      endcase
      r.sample = r.fail ? 24'($urandom) : r.sample;
      send(r);
    end
  endtask

  task automatic load_table(bit ascending);
    int i;
    int signed a;
    a = -8388608 + $urandom_range(1000);
    for (i = 0; i < NPTS; i++) begin
      if (ascending) a = a + $urandom_range(2000000);
      else a = $urandom;
      send(mk(OP_WRITE, 0, 0, i, a, $urandom));
    end
  endtask

  // sink with random stalls and one long hold-off
  always @(posedge clk) begin
    reading_t got, e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[23:0], m_tdata[55:24], m_tuser[0], m_tdata[87:56], m_tuser[1]};
        if (pending_q.size() == 0) begin
          $display("%0t unexpected word: actual %h", $time, got);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (got !== e) begin
            $display("%0t mismatch: expected raw %0d wgt %0d stb %0b offs %0d ref %0b",
                     $time, e.raw, e.wgt, e.stb, e.offs, e.refused);
            $display("%0t          actual   raw %0d wgt %0d stb %0b offs %0d ref %0b",
                     $time, got.raw, got.wgt, got.stb, got.offs, got.refused);
            errors++;
          end
        end
      end
      m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    row_t dir[$];
    row_t r;
    n_pts = 0; f_shift = 0; f_band = 0; r_step = 0;
    z_band = 0; z_delay = 0; s_band = 0; s_delay = 0;
    filt = 0; offs_m = 0; last_w = 0; s_ref = 0; seeded = 0; s_flag = 0;
    z_cnt = 0; s_cnt = 0;
    for (int i = 0; i < NPTS; i++) begin
      tab_adc[i] = 0; tab_wgt[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: points_in_use is 0, so weight stays zero
    r = mk(OP_SAMPLE, 0, 24'sh7fffff, 0, 0, 0); r.has_exp = 1;
    r.exp_r = '{24'sh7fffff, 0, 1, 0, 0}; dir.push_back(r);
    r = mk(OP_SAMPLE, 0, -24'sh800000, 0, 0, 0); r.has_exp = 1;
    r.exp_r = '{-24'sh800000, 0, 1, 0, 0}; dir.push_back(r);
    r = mk(OP_SAMPLE, 1, 24'h123456, 0, 0, 0); r.has_exp = 1;
    r.exp_r = '{FAIL_MARK, 0, 1, 0, 0}; dir.push_back(r);
    r = mk(OP_ZERO, 0, 0, 0, 0, 0); r.has_exp = 1;
    r.exp_r = '{0, 0, 1, 0, 0}; dir.push_back(r);
    r = mk(OP_NONE, 0, 0, 0, 0, 0); r.has_exp = 1;
    r.exp_r = '{0, 0, 1, 0, 0}; dir.push_back(r);
    dir.push_back(mk(OP_WRITE, 0, 0, 0, -24'sh800000, 32'sh80000000));
    dir.push_back(mk(OP_WRITE, 0, 0, 1, 0, 0));
    dir.push_back(mk(OP_WRITE, 0, 0, 2, 0, 1000));
    dir.push_back(mk(OP_WRITE, 0, 0, 3, 24'sh7fffff, 32'sh7fffffff));
    dir.push_back(mk(OP_WRITE, 0, 0, 4, 100, -5));
    dir.push_back(mk(OP_WRITE, 0, 0, 5, 200, 7));
    dir.push_back(mk(OP_WRITE, 0, 0, 6, 300, 32'sh7fffffff));
    dir.push_back(mk(OP_WRITE, 0, 0, 7, 24'sh7fffff, 32'sh80000000));
    foreach (dir[i]) send(dir[i]);
    drain();

    write_reg(REG_POINTS, 15);
    write_reg(REG_ROUND_STEP, 65535);
    write_reg(REG_STEADY_DELAY, 0);
    dir.delete();
    dir.push_back(mk(OP_SAMPLE, 0, -24'sh800000, 0, 0, 0));
    dir.push_back(mk(OP_SAMPLE, 0, -1, 0, 0, 0));
    dir.push_back(mk(OP_SAMPLE, 0, 0, 0, 0, 0));
    dir.push_back(mk(OP_SAMPLE, 0, 150, 0, 0, 0));
    dir.push_back(mk(OP_SAMPLE, 0, 24'sh7fffff, 0, 0, 0));
    dir.push_back(mk(OP_ZERO, 0, 0, 0, 0, 0));
    dir.push_back(mk(OP_SAMPLE, 0, 24'sh7fffff, 0, 0, 0));
    dir.push_back(mk(OP_SAMPLE, 0, 250, 0, 0, 0));
    dir.push_back(mk(OP_ZERO, 0, 0, 0, 0, 0));
    foreach (dir[i]) send(dir[i]);
    drain();

    // phase A: ascending table, moderate filter, tracking and stability
    write_reg(REG_POINTS, 5);
    write_reg(REG_FILTER_SHIFT, 2);
    write_reg(REG_BAND_LIMIT, 100);
    write_reg(REG_ROUND_STEP, 5);
    write_reg(REG_ZERO_BAND, 200);
    write_reg(REG_ZERO_DELAY, 1);
    write_reg(REG_STEADY_BAND, 300);
    write_reg(REG_STEADY_DELAY, 1);
    load_table(1);
    random_items(450);

    // long receiver hold-off while samples keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        random_items(30);
        s_tvalid <= 1'b0;
      end
    join
    drain();

    // phase B: idling swapped, extreme registers
    send_idle = 72; recv_idle = 12;
    write_reg(REG_POINTS, 8);
    write_reg(REG_FILTER_SHIFT, 31);
    write_reg(REG_BAND_LIMIT, 23'h7fffff);
    write_reg(REG_ROUND_STEP, 1);
    write_reg(REG_ZERO_BAND, 65535);
    write_reg(REG_ZERO_DELAY, 255);
    write_reg(REG_STEADY_BAND, 65535);
    write_reg(REG_STEADY_DELAY, 255);
    load_table(0);
    random_items(450);
    drain();

    // phase C: no idling; unfiltered with a small table, then filtered with a full table
    send_idle = 0; recv_idle = 0;
    write_reg(REG_POINTS, 2);
    write_reg(REG_FILTER_SHIFT, 0);
    write_reg(REG_BAND_LIMIT, 0);
    write_reg(REG_ROUND_STEP, 0);
    write_reg(REG_ZERO_BAND, 0);
    write_reg(REG_ZERO_DELAY, 0);
    write_reg(REG_STEADY_BAND, 0);
    write_reg(REG_STEADY_DELAY, 0);
    random_items(400);
    drain();
    write_reg(REG_POINTS, 8);
    write_reg(REG_FILTER_SHIFT, 4);
    write_reg(REG_BAND_LIMIT, 5000);
    write_reg(REG_ROUND_STEP, 10);
    write_reg(REG_ZERO_BAND, 50);
    write_reg(REG_ZERO_DELAY, 0);
    write_reg(REG_STEADY_BAND, 20);
    write_reg(REG_STEADY_DELAY, 2);
    load_table(1);
    random_items(400);
    drain();

    if (errors == 0)
      $display("load_cell_weight_processor_unit verification clean");
    else
      $display("load_cell_weight_processor_unit verification failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("load_cell_weight_processor_unit verification failed");
    $finish;
  end

endmodule
